@@ rtl/rn_pkg.sv @@
// Package for the rational normalise block: widths, sequencer states and
// the structs passed between the sequencer, the shared divider and the top level.
// No dependencies.
package rn_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned MAG_W   = 31;
  localparam int unsigned STEP_W  = $clog2(WORD_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WORD_W - 1);
  localparam logic [MAG_W-1:0]  MAG_MAX   = {MAG_W{1'b1}};
  localparam logic [MAG_W-1:0]  MAG_ONE   = MAG_W'(1);

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_DONE
  } rn_state_t;

  // Request to the shared divider
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  // Status and results from the shared divider
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WORD_W-1:0] quotient;
    logic [WORD_W-1:0] remainder;
  } div_rsp_t;

  // One finished result from the sequencer
  typedef struct packed {
    logic [WORD_W-1:0] num;
    logic [MAG_W-1:0]  den;
    logic              is_int;
    logic              dbz;
  } rn_result_t;

endpackage

@@ rtl/rn_div.sv @@
// Shared unsigned restoring divider, one quotient bit per cycle.
// Depends on rn_pkg.
module rn_div (
  input  logic            clk,
  input  logic            rst_n,
  input  rn_pkg::div_req_t req,
  output rn_pkg::div_rsp_t rsp
);
  import rn_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   cnt_r, cnt_nxt;
  logic [WORD_W-1:0]   rem_r, rem_nxt;
  logic [WORD_W-1:0]   quo_r, quo_nxt;
  logic [WORD_W-1:0]   dsr_r, dsr_nxt;
  logic [WORD_W:0]     shifted;
  logic [WORD_W+1:0]   diff;
  logic                fits;

  // trial subtract of the divisor from the shifted partial remainder
  assign shifted = {rem_r, quo_r[WORD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_r};
  assign fits    = ~diff[WORD_W+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
      quo_nxt = {quo_r[WORD_W-2:0], fits};
      cnt_nxt = cnt_r + STEP_W'(1);
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.busy      = busy_r;
  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("divider started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while still busy");
  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && dsr_r != '0) |-> (rem_r < dsr_r)) else $error("remainder not below divisor");

endmodule

@@ rtl/rn_seq.sv @@
// Sequencer: Euclid's remainder loop and the two exact divisions on the
// shared divider, then sign and saturation. Depends on rn_pkg.
module rn_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [rn_pkg::WORD_W-1:0] in_num,
  input  logic [rn_pkg::WORD_W-1:0] in_den,
  output rn_pkg::div_req_t          div_req,
  input  rn_pkg::div_rsp_t          div_rsp,
  output logic                      res_valid,
  input  logic                      res_ready,
  output rn_pkg::rn_result_t        res
);
  import rn_pkg::*;

  rn_state_t          state_r, state_nxt;
  logic               start_r, start_nxt;
  logic [WORD_W-1:0]  an_r, an_nxt;
  logic [WORD_W-1:0]  ad_r, ad_nxt;
  logic [WORD_W-1:0]  a_r, a_nxt;
  logic [WORD_W-1:0]  b_r, b_nxt;
  logic [WORD_W-1:0]  rn_r, rn_nxt;
  logic [WORD_W-1:0]  rd_r, rd_nxt;
  logic               neg_r, neg_nxt;
  logic               dbz_r, dbz_nxt;
  logic               accept;
  logic [WORD_W-1:0]  mag_n, mag_d;
  logic [MAG_W-1:0]   rn_sat, rd_sat;

  assign accept = in_valid & in_ready;
  assign mag_n  = in_num[WORD_W-1] ? (WORD_W'(0) - in_num) : in_num;
  assign mag_d  = in_den[WORD_W-1] ? (WORD_W'(0) - in_den) : in_den;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = (in_den == '0) ? ST_DONE : ST_GCD;
      ST_GCD:  if (div_rsp.done && div_rsp.remainder == '0) state_nxt = ST_DIVN;
      ST_DIVN: if (div_rsp.done) state_nxt = ST_DIVD;
      ST_DIVD: if (div_rsp.done) state_nxt = ST_DONE;
      ST_DONE: if (res_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    start_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        start_nxt = in_valid && (in_den != '0);
      end
      ST_GCD:  start_nxt = div_rsp.done;
      ST_DIVN: start_nxt = div_rsp.done;
      ST_DIVD: start_nxt = 1'b0;
      ST_DONE: res_valid = 1'b1;
      default: start_nxt = 1'b0;
    endcase
  end

  // datapath updates
  always_comb begin
    an_nxt  = an_r;
    ad_nxt  = ad_r;
    a_nxt   = a_r;
    b_nxt   = b_r;
    rn_nxt  = rn_r;
    rd_nxt  = rd_r;
    neg_nxt = neg_r;
    dbz_nxt = dbz_r;
    if (accept) begin
      an_nxt  = mag_n;
      ad_nxt  = mag_d;
      a_nxt   = mag_n;
      b_nxt   = mag_d;
      neg_nxt = in_num[WORD_W-1] ^ in_den[WORD_W-1];
      dbz_nxt = (in_den == '0);
      rn_nxt  = '0;
      rd_nxt  = '0;
    end else if (div_rsp.done) begin
      if (state_r == ST_GCD && div_rsp.remainder != '0) begin
        a_nxt = b_r;
        b_nxt = div_rsp.remainder;
      end
      if (state_r == ST_DIVN) rn_nxt = div_rsp.quotient;
      if (state_r == ST_DIVD) rd_nxt = div_rsp.quotient;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    an_r  <= an_nxt;
    ad_r  <= ad_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    rn_r  <= rn_nxt;
    rd_r  <= rd_nxt;
    neg_r <= neg_nxt;
    dbz_r <= dbz_nxt;
  end

  // divider operands: remainder step in GCD, then each magnitude over the divisor
  always_comb begin
    div_req.start    = start_r;
    div_req.divisor  = b_r;
    div_req.dividend = a_r;
    if (state_r == ST_DIVN) div_req.dividend = an_r;
    else if (state_r == ST_DIVD) div_req.dividend = ad_r;
  end

  // saturate the magnitudes, then put the sign on the numerator
  assign rn_sat     = rn_r[WORD_W-1] ? MAG_MAX : rn_r[MAG_W-1:0];
  assign rd_sat     = rd_r[WORD_W-1] ? MAG_MAX : rd_r[MAG_W-1:0];
  assign res.num    = (neg_r && rn_sat != '0) ? (WORD_W'(0) - {1'b0, rn_sat}) : {1'b0, rn_sat};
  assign res.den    = rd_sat;
  assign res.is_int = (rd_sat == MAG_ONE);
  assign res.dbz    = dbz_r;

  a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.dbz) |-> (res.num == '0 && res.den == '0 && !res.is_int))
    else $error("divide-by-zero result not cleared");
  a_dbz_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_den == '0) |=> (state_r == ST_DONE && !start_r))
    else $error("zero denominator did not skip the divider");
  a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_GCD || state_r == ST_DIVN || state_r == ST_DIVD))
    else $error("divider finished outside a divide state");

endmodule

@@ rtl/rational_normalize_core.sv @@
// Top level of the rational normalise block: stream ports, shared divider,
// sequencer and output register. Depends on rn_pkg, rn_div and rn_seq.
// Flow: a zero denominator skips the divider; any other input runs the Euclid remainder
//   steps, then the two exact divisions, each division loading, producing 32 quotient bits and handing off.
// Transactions: one at a time; the next is taken only once the result has gone to the output register.
// Reset: synchronous active-low rst_n clears the sequencer, divider and out_tvalid.
module rational_normalize_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] numerator, [63:32] denominator
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] reduced_numerator, [62:32] reduced_denominator, [63] 0
  output logic [1:0]  out_tuser   // [0] is_integer, [1] divide_by_zero
);
  import rn_pkg::*;

  div_req_t   div_req;
  div_rsp_t   div_rsp;
  rn_result_t res;
  logic       res_valid;
  logic       res_ready;
  logic       out_tvalid_r;
  rn_result_t out_r;

  rn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  rn_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_num    (in_tdata[WORD_W-1:0]),
    .in_den    (in_tdata[2*WORD_W-1:WORD_W]),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register, loaded when empty or being drained
  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_r.den, out_r.num};
  assign out_tuser  = {out_r.dbz, out_r.is_int};

endmodule

@@ tb/rn_fraction_checker.sv @@
// Checker for the rational normalise block: watches both stream channels,
// predicts each reduced fraction and compares it field by field.
// Depends on rn_pkg for the word and magnitude widths.
`timescale 1ns / 100ps

module rn_fraction_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] numerator, [63:32] denominator
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,  // [31:0] reduced_numerator, [62:32] reduced_denominator
  input  logic [1:0]  out_tuser,  // [0] is_integer, [1] divide_by_zero
  output int unsigned mismatch_count,
  output int unsigned pending_count
);
  import rn_pkg::*;

  // One expected fraction, with the operands that caused it
  typedef struct packed {
    logic [WORD_W-1:0] num_in;
    logic [WORD_W-1:0] den_in;
    logic [WORD_W-1:0] red_num;
    logic [MAG_W-1:0]  red_den;
    logic              is_int;
    logic              dbz;
  } fraction_t;

  fraction_t reduced_q[$];

  // Euclid on the magnitudes, divide out, saturate, then put the sign on top
  function automatic fraction_t reduce_fraction(input logic [WORD_W-1:0] num,
                                                input logic [WORD_W-1:0] den);
    fraction_t         r;
    logic [WORD_W-1:0] an, ad, a, b, rem, rn, rd;
    logic              neg;
    r        = '0;
    r.num_in = num;
    r.den_in = den;
    if (den == '0) begin
      r.dbz = 1'b1;
      return r;
    end
    an  = num[WORD_W-1] ? WORD_W'(0) - num : num;
    ad  = den[WORD_W-1] ? WORD_W'(0) - den : den;
    a   = an;
    b   = ad;
    rem = a % b;
    while (rem != '0) begin
      a   = b;
      b   = rem;
      rem = a % b;
    end
    rn = an / b;
    rd = ad / b;
    if (rn > {1'b0, MAG_MAX}) rn = {1'b0, MAG_MAX};
    if (rd > {1'b0, MAG_MAX}) rd = {1'b0, MAG_MAX};
    neg       = (rn != '0) && (num[WORD_W-1] ^ den[WORD_W-1]);
    r.red_num = neg ? WORD_W'(0) - rn : rn;
    r.red_den = rd[MAG_W-1:0];
    r.is_int  = (rd == WORD_W'(1));
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v, input logic [31:0] num_in,
                                 input logic [31:0] den_in);
    $display("%0t ns: mismatch on %s: got %08h, want %08h (operands %0d / %0d)",
             $time, what, got_v, want_v, $signed(num_in), $signed(den_in));
    mismatch_count++;
  endtask

  // Log each input transaction and check each result transaction
  always @(posedge clk) begin
    fraction_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        reduced_q.push_back(reduce_fraction(in_tdata[31:0], in_tdata[63:32]));
      if (out_tvalid && out_tready) begin
        if (reduced_q.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[31:0], '0, '0, '0);
        end else begin
          want = reduced_q.pop_front();
          if (out_tdata[31:0] !== want.red_num)
            report_mismatch("reduced_numerator", out_tdata[31:0], want.red_num,
                            want.num_in, want.den_in);
          if (out_tdata[62:32] !== want.red_den)
            report_mismatch("reduced_denominator", 32'(out_tdata[62:32]),
                            32'(want.red_den), want.num_in, want.den_in);
          if (out_tuser[0] !== want.is_int)
            report_mismatch("is_integer", 32'(out_tuser[0]), 32'(want.is_int),
                            want.num_in, want.den_in);
          if (out_tuser[1] !== want.dbz)
            report_mismatch("divide_by_zero", 32'(out_tuser[1]), 32'(want.dbz),
                            want.num_in, want.den_in);
        end
      end
    end
    pending_count <= reduced_q.size();
  end

endmodule

@@ tb/tb_rational_normalize_core.sv @@
// Testbench top for rational_normalize_core: clock, reset, fraction stimulus,
// random back-pressure on the result channel and the final verdict.
// Depends on rn_pkg, the block's RTL and rn_fraction_checker.
`timescale 1ns / 100ps

module tb_rational_normalize_core;

  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned PAUSE_AT     = 250;
  localparam int unsigned TAIL_CYCLES  = 2000;
  localparam int unsigned CYCLE_LIMIT  = 6_000_000;
  localparam logic [31:0] POS_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0] MOST_NEG     = 32'h8000_0000;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned sent_count = 0;
  int unsigned cycle_count = 0;

  rational_normalize_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  rn_fraction_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Any 32-bit word but the most negative one
  function automatic logic [31:0] any_word();
    logic [31:0] w;
    w = $urandom;
    if (w == MOST_NEG) w = MOST_NEG + 1;
    return w;
  endfunction

  function automatic logic [31:0] maybe_negate(input logic [31:0] v);
    return $urandom_range(0, 1) ? 32'd0 - v : v;
  endfunction

  // One input transaction; returns at the accepting edge with tvalid still high
  task automatic send_fraction(input logic [31:0] num, input logic [31:0] den);
    int unsigned gap;
    gap = (((sent_count / 40) % 3) == 1) ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {den, num};
    do @(posedge clk); while (!in_tready);
    sent_count++;
  endtask

  // Random fraction, often with a shared factor so that reduction does work
  task automatic send_random_fraction();
    logic [31:0] g, lim, a, b;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        g   = $urandom_range(1, 32'd1 << $urandom_range(0, 30));
        lim = POS_MAX / g;
        a   = $urandom_range(0, lim);
        b   = $urandom_range(1, lim);
        send_fraction(maybe_negate(a * g), maybe_negate(b * g));
      end
      4, 5: send_fraction(any_word(), any_word());
      6: send_fraction(maybe_negate($urandom_range(0, 100)),
                       maybe_negate($urandom_range(1, 100)));
      7: send_fraction(any_word(), 32'd0);
      8: send_fraction(32'd0, any_word());
      default: begin
        b = $urandom_range(1, 1000);
        a = $urandom_range(0, POS_MAX / b);
        send_fraction(maybe_negate(a * b), maybe_negate(b));
      end
    endcase
  endtask

  // Result channel back-pressure, with stretches of constant ready
  initial begin
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = (((taken / 40) % 3) == 2) ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      taken++;
    end
  end

  // Stimulus and verdict
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero denominators
    send_fraction(32'd0, 32'd0);
    send_fraction(32'd5, 32'd0);
    send_fraction(32'd0 - 32'd7, 32'd0);
    // Zero numerator gives 0/1
    send_fraction(32'd0, 32'd5);
    send_fraction(32'd0, 32'd0 - 32'd5);
    // Sign placement
    send_fraction(32'd6, 32'd4);
    send_fraction(32'd0 - 32'd6, 32'd4);
    send_fraction(32'd6, 32'd0 - 32'd4);
    send_fraction(32'd0 - 32'd6, 32'd0 - 32'd4);
    send_fraction(32'd12, 32'd3);
    send_fraction(32'd3, 32'd12);
    send_fraction(32'd1, 32'd1);
    // Range extremes
    send_fraction(POS_MAX, POS_MAX);
    send_fraction(POS_MAX, 32'd0 - POS_MAX);
    send_fraction(32'd0 - POS_MAX, 32'd1);
    send_fraction(32'd1, POS_MAX);
    send_fraction(POS_MAX, POS_MAX - 1);
    send_fraction(32'd1 << 30, 32'd1 << 29);
    // Consecutive Fibonacci numbers: the longest remainder chain
    send_fraction(32'd1836311903, 32'd1134903170);
    send_fraction(32'd0 - 32'd1134903170, 32'd1836311903);
    // Most negative word: a reduced magnitude of 2^31 saturates
    send_fraction(MOST_NEG, 32'd1);
    send_fraction(32'd1, MOST_NEG);
    send_fraction(MOST_NEG, MOST_NEG);
    send_fraction(MOST_NEG, 32'd6);

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      // Hold off once until the block has drained completely
      if (i == PAUSE_AT) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
      end
      send_random_fraction();
    end
    in_tvalid <= 1'b0;

    do @(posedge clk); while (pending_count != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
